>>> rtl/core/npd_pkg.sv
// npd_pkg: shared constants, word table and types for the phonetic decoder
// no dependencies; used by every file in rtl/core
package npd_pkg;

   localparam int WordChars = 8;
   localparam int LenBits   = $clog2(WordChars + 2);
   localparam int IdxBits   = $clog2(WordChars);
   localparam int NumWords  = 26;

   typedef logic [7:0] char_type;
   typedef logic [WordChars*8-1:0] word_bits_type;
   typedef logic [LenBits-1:0] len_type;

   typedef struct packed {
      logic [1:0] count;
      char_type   char0;
      char_type   char1;
   } result_type;

   localparam char_type CharNul    = 8'h00;
   localparam char_type CharLf     = 8'h0a;
   localparam char_type CharCr     = 8'h0d;
   localparam char_type CharSpace  = 8'h20;
   localparam char_type CharUpperA = 8'h41;
   localparam char_type CharUpperZ = 8'h5a;
   localparam char_type LetterBase = 8'h61;

   localparam word_bits_type WordText [NumWords] = '{
      "Alfa", "Bravo", "Charlie", "Delta", "Echo", "Foxtrot", "Golf",
      "Hotel", "India", "Juliett", "Kilo", "Lima", "Mike", "November",
      "Oscar", "Papa", "Quebec", "Romeo", "Sierra", "Tango", "Uniform",
      "Victor", "Whiskey", "X-ray", "Yankee", "Zulu"
   };

   localparam int WordLen [NumWords] = '{
      4, 5, 7, 5, 4, 7, 4, 5, 5, 7, 4, 4, 4, 8, 5, 4, 6, 5, 6, 5, 7, 6, 7, 5, 6, 4
   };

   // first character moved to the top byte
   function automatic word_bits_type word_left(int w);
      return WordText[w] << ((WordChars - WordLen[w]) * 8);
   endfunction

endpackage

>>> rtl/core/npd_req_if.sv
// npd_req_if: valid/ready channel carrying one text byte per item
// depends on npd_pkg
interface npd_req_if;
   logic              valid;
   logic              ready;
   npd_pkg::char_type in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

>>> rtl/core/npd_rsp_if.sv
// npd_rsp_if: valid/ready channel carrying one decoded character per item
// depends on npd_pkg
interface npd_rsp_if;
   logic              valid;
   logic              ready;
   npd_pkg::char_type out_char;
   logic              last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

>>> rtl/core/npd_matcher.sv
// npd_matcher: compares the segment buffer against all phonetic words at once
// depends on npd_pkg
module npd_matcher (
   input  npd_pkg::char_type seg_buf [npd_pkg::WordChars],
   input  npd_pkg::len_type  seg_len,
   output logic              hit,
   output npd_pkg::char_type letter
);

   logic [npd_pkg::NumWords-1:0] word_hit;

   always_comb begin
      letter = npd_pkg::LetterBase;
      for (int w = 0; w < npd_pkg::NumWords; w++) begin
         npd_pkg::word_bits_type word_bits;
         word_bits   = npd_pkg::word_left(w);
         word_hit[w] = (seg_len == npd_pkg::LenBits'(npd_pkg::WordLen[w]));
         for (int k = 0; k < npd_pkg::WordChars; k++) begin
            if (k < npd_pkg::WordLen[w] && seg_buf[k] !=
                word_bits[(npd_pkg::WordChars-1-k)*8 +: 8]) begin
               word_hit[w] = 1'b0;
            end
         end
         if (word_hit[w]) begin
            letter = npd_pkg::LetterBase + 8'(w);
         end
      end
      hit = |word_hit;
   end

endmodule

>>> rtl/core/npd_segment.sv
// npd_segment: segment buffer, length and boundary state; builds results per byte
// depends on npd_pkg and npd_matcher
module npd_segment (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  npd_pkg::char_type    char_in,
   output npd_pkg::result_type  result
);

   npd_pkg::char_type buf_ff [npd_pkg::WordChars];
   npd_pkg::len_type  len_ff, len_in;
   logic              seen_ff, seen_in;
   logic              wr_en;
   npd_pkg::char_type wr_data;
   logic [npd_pkg::IdxBits-1:0] wr_addr;

   logic              is_bnd, is_space, is_nul, hit, emit;
   npd_pkg::char_type letter;

   npd_matcher u_matcher (
      .seg_buf (buf_ff),
      .seg_len (len_ff),
      .hit     (hit),
      .letter  (letter)
   );

   assign is_space = (char_in == npd_pkg::CharSpace);
   assign is_nul   = (char_in == npd_pkg::CharNul);
   assign is_bnd   = (char_in >= npd_pkg::CharUpperA && char_in <= npd_pkg::CharUpperZ) ||
                     is_nul || is_space || char_in == npd_pkg::CharCr ||
                     char_in == npd_pkg::CharLf;
   assign emit     = is_bnd && seen_ff && hit;

   always_comb begin
      result.count = {1'b0, emit} + {1'b0, is_space};
      result.char0 = emit ? letter : npd_pkg::CharSpace;
      result.char1 = npd_pkg::CharSpace;
   end

   always_comb begin
      len_in  = len_ff;
      seen_in = seen_ff;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = char_in;
      if (step) begin
         if (is_nul) begin
            len_in  = '0;
            seen_in = 1'b0;
         end else if (is_space || (is_bnd && seen_ff)) begin
            // restart the segment at this byte
            seen_in = 1'b1;
            len_in  = npd_pkg::len_type'(1);
            wr_en   = 1'b1;
         end else begin
            seen_in = seen_ff | is_bnd;
            if (len_ff < npd_pkg::len_type'(npd_pkg::WordChars)) begin
               wr_en   = 1'b1;
               wr_addr = len_ff[npd_pkg::IdxBits-1:0];
               len_in  = len_ff + npd_pkg::len_type'(1);
            end else begin
               len_in = npd_pkg::len_type'(npd_pkg::WordChars + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_ff[wr_addr] <= wr_data;
      end
   end

endmodule

>>> rtl/core/npd_rsp_queue.sv
// npd_rsp_queue: two-entry result register that drains one item per cycle while rsp_ch is ready
// depends on npd_pkg and npd_rsp_if
module npd_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  npd_pkg::result_type result,
   output logic                can_load,
   npd_rsp_if.source           rsp_ch
);

   logic [1:0]        cnt_ff, cnt_in;
   npd_pkg::char_type c0_ff, c0_in;
   npd_pkg::char_type c1_ff, c1_in;
   logic              pop;

   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign can_load = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ch.ready);

   assign rsp_ch.valid       = (cnt_ff != 2'd0);
   assign rsp_ch.out_char    = c0_ff;
   assign rsp_ch.last_of_run = (cnt_ff == 2'd1);

   always_comb begin
      cnt_in = cnt_ff;
      c0_in  = c0_ff;
      c1_in  = c1_ff;
      if (load) begin
         cnt_in = result.count;
         c0_in  = result.char0;
         c1_in  = result.char1;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         c0_in  = c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      c0_ff <= c0_in;
      c1_ff <= c1_in;
   end

endmodule

>>> rtl/core/nato_phonetic_decoder.sv
// nato_phonetic_decoder: top level of the phonetic word decoder
// depends on npd_pkg, npd_req_if, npd_rsp_if, npd_segment, npd_rsp_queue
//
// usage
//   req_ch carries one text byte per item; byte 0 ends the text and clears state
//   rsp_ch carries decoded lowercase letters and echoed spaces; last_of_run
//   marks the final item caused by one input byte
//   a byte produces zero, one or two items (letter, then space)
// an accepted byte is held in the input register, then its items in the result register
// throughput: one byte per cycle while rsp_ch is ready; a byte with two items
//   holds the input while the two-entry result register drains
// reset (synchronous, active high): segment length and boundary flag clear,
//   input and result registers empty; the segment buffer is not cleared
// receiver stall: results wait in the result register, one more byte waits
//   in the input register, then req_ch.ready drops until rsp_ch drains
module nato_phonetic_decoder (
   input  logic      clock,
   input  logic      reset,
   npd_req_if.sink   req_ch,
   npd_rsp_if.source rsp_ch
);

   logic                in_valid_ff, in_valid_in;
   npd_pkg::char_type   in_char_ff, in_char_in;
   logic                can_load, process, accept;
   npd_pkg::result_type result;

   assign process      = in_valid_ff && can_load;
   assign req_ch.ready = !in_valid_ff || process;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      in_char_in  = accept ? req_ch.in_char : in_char_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
   end

   npd_segment u_segment (
      .clock   (clock),
      .reset   (reset),
      .step    (process),
      .char_in (in_char_ff),
      .result  (result)
   );

   npd_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (process),
      .result   (result),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule
